/* design/mbrd_pkg.sv */
// Shared types and constants for the Modbus RTU request decoder.
// Used by mbrd_crc16, mbrd_parser and the top level; no dependencies.
package mbrd_pkg;

    // Function byte values on the wire
    localparam logic [7:0] FUNC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FUNC_WRITE_ONE   = 8'h06;
    localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] FUNC_SPECIAL     = 8'hFF;

    // Reported function codes
    localparam logic [1:0] FC_READ_HOLD   = 2'd0;
    localparam logic [1:0] FC_WRITE_ONE   = 2'd1;
    localparam logic [1:0] FC_WRITE_MULTI = 2'd2;
    localparam logic [1:0] FC_SPECIAL     = 2'd3;

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_IGNORE = 2'd1,
        ST_ERROR  = 2'd2
    } t_status;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;

    // APB register decode (paddr[2] selects the register word)
    localparam logic REG_DEVICE_ADDR = 1'b0;

    typedef struct packed {
        logic        valid;
        logic        kind;
        t_status     status;
        logic [1:0]  func_code;
        logic [15:0] reg_start;
        logic [15:0] count_val;
        logic [7:0]  byte_cnt;
        logic [15:0] data_word;
    } t_result;

endpackage

/* design/modbus_rtu_request_decoder_unit.sv */
// Top level of the Modbus RTU request decoder: stream ports, APB register, pipeline regs.
// Depends on mbrd_pkg and mbrd_parser.
//
// Usage:
//  - Slave stream: one frame byte per transaction in s_axis tdata[7:0], tlast on the
//    frame's last byte.
//  - Master stream: zero or one result per byte. tuser = kind (0 data word, 1 verdict).
//    Data words come for an addressed write-multiple request on each completed data
//    pair; the last byte always yields a verdict (accepted / ignored / error).
//  - APB register 0 (byte address 0): device address, reset 1. Write only while idle.
//  - Path: a byte is taken into the input register, and its result is then captured in
//    the result register, which drives the master side.
//  - Throughput: one byte per cycle while the master side takes results; the CRC byte
//    step, header capture and verdict all sit in the single logic stage between the two registers.
//  - Stall: with the result register full and tready low, the input register holds
//    one more byte; after that s_axis tready drops until the result is taken.
//  - Reset (synchronous, active low) empties both registers, clears the frame state
//    and sets the device address to 1.
module modbus_rtu_request_decoder_unit #(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tlast,   // frame_end
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [3:2] function_code, [19:4] start_address,
    // [35:20] count_or_value, [43:36] byte_count, [59:44] data_word, [63:60] zero
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // kind
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;
    logic              r_out_valid;
    mbrd_pkg::t_result r_out;
    logic [7:0]        r_dev_addr;

    logic              w_step;
    mbrd_pkg::t_result w_result;

    // stage advances when the result register is free or being drained
    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mbrd_pkg::REG_DEVICE_ADDR) ? {24'h0, r_dev_addr} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= mbrd_pkg::DEV_ADDR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == mbrd_pkg::REG_DEVICE_ADDR) begin
            r_dev_addr <= pwdata[7:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    mbrd_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .i_end      (r_in_end),
        .i_dev_addr (r_dev_addr),
        .o_result   (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_result.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {4'h0, r_out.data_word, r_out.byte_cnt, r_out.count_val,
                              r_out.reg_start, r_out.func_code, r_out.status};

    // assertions
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3)
        else $error("illegal status code");

    a_data_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == mbrd_pkg::KIND_DATA) |->
        (o_m_axis_tdata[3:2] == mbrd_pkg::FC_WRITE_MULTI &&
         o_m_axis_tdata[1:0] == mbrd_pkg::ST_ACCEPT))
        else $error("data word without write-multiple header");

    a_reject_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == mbrd_pkg::KIND_VERDICT &&
         o_m_axis_tdata[1:0] != mbrd_pkg::ST_ACCEPT) |-> o_m_axis_tdata[63:2] == 62'h0)
        else $error("rejected verdict carries header fields");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_end)))
        else $error("input register lost a pending byte");

endmodule

/* design/mbrd_crc16.sv */
// One-byte step of CRC-16/MODBUS (reflected, poly 0xA001).
// Depends on mbrd_pkg for the polynomial constant.
module mbrd_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mbrd_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* design/mbrd_parser.sv */
// Frame state and per-byte decode: header capture, lagged CRC, data words, verdict.
// Depends on mbrd_pkg and mbrd_crc16.
module mbrd_parser #(
    parameter int MAX_FRAME = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  logic [7:0]        i_dev_addr,
    output mbrd_pkg::t_result o_result
);

    localparam int POS_W = $clog2(MAX_FRAME + 2);
    localparam int CW    = (POS_W > 9) ? POS_W + 1 : 10;
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_FRAME + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME);

    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_dly0, n_dly0;
    logic [7:0]       r_dly1, n_dly1;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_func, n_func;
    logic [15:0]      r_addr, n_addr;
    logic [15:0]      r_cnt, n_cnt;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_hold, n_hold;
    logic             r_match, n_match;

    logic [15:0]      w_crc_step;

    mbrd_crc16 u_crc (
        .i_crc  (r_crc),
        .i_byte (r_dly0),
        .o_crc  (w_crc_step)
    );

    always_comb begin
        logic [15:0]      crc_upd;
        logic             h_match;
        logic [7:0]       h_func;
        logic [15:0]      h_addr;
        logic [15:0]      h_cnt;
        logic [7:0]       h_len;
        logic             known;
        logic [1:0]       fc;
        logic [CW-1:0]    expect_m1;
        logic [POS_W-1:0] off;
        logic             bad;

        crc_upd = (r_pos >= POS_W'(2)) ? w_crc_step : r_crc;

        h_match = r_match;
        h_func  = r_func;
        h_addr  = r_addr;
        h_cnt   = r_cnt;
        h_len   = r_len;
        if (r_pos == POS_W'(0)) h_match = (i_byte == i_dev_addr);
        if (r_pos == POS_W'(1)) h_func = i_byte;
        if (r_pos == POS_W'(2)) h_addr = {i_byte, r_addr[7:0]};
        if (r_pos == POS_W'(3)) h_addr = {r_addr[15:8], i_byte};
        if (r_pos == POS_W'(4)) h_cnt = {i_byte, r_cnt[7:0]};
        if (r_pos == POS_W'(5)) h_cnt = {r_cnt[15:8], i_byte};
        if (r_pos == POS_W'(6)) h_len = i_byte;

        known     = 1'b1;
        fc        = mbrd_pkg::FC_READ_HOLD;
        expect_m1 = CW'(7);
        unique case (h_func)
            mbrd_pkg::FUNC_READ_HOLD: begin
                fc = mbrd_pkg::FC_READ_HOLD;
                expect_m1 = CW'(7);
            end
            mbrd_pkg::FUNC_WRITE_ONE: begin
                fc = mbrd_pkg::FC_WRITE_ONE;
                expect_m1 = CW'(7);
            end
            mbrd_pkg::FUNC_WRITE_MULTI: begin
                fc = mbrd_pkg::FC_WRITE_MULTI;
                expect_m1 = CW'(8) + CW'(h_len);
            end
            mbrd_pkg::FUNC_SPECIAL: begin
                fc = mbrd_pkg::FC_SPECIAL;
                expect_m1 = CW'(3);
            end
            default: begin
                known = 1'b0;
            end
        endcase

        // defaults: shift delay line, advance position
        n_crc   = crc_upd;
        n_match = h_match;
        n_func  = h_func;
        n_addr  = h_addr;
        n_cnt   = h_cnt;
        n_len   = h_len;
        n_hold  = r_hold;
        n_dly0  = r_dly1;
        n_dly1  = i_byte;
        n_pos   = (r_pos < POS_SAT) ? r_pos + POS_W'(1) : r_pos;
        o_result = '0;
        off = r_pos - POS_W'(7);
        bad = (r_dly1 != crc_upd[7:0]) || (i_byte != crc_upd[15:8]) ||
              (CW'(r_pos) != expect_m1);

        if (i_end) begin
            o_result.valid = 1'b1;
            o_result.kind  = mbrd_pkg::KIND_VERDICT;
            if (r_pos < POS_W'(3) || r_pos >= POS_MAX) begin
                o_result.status = mbrd_pkg::ST_ERROR;
            end else if (!h_match || !known) begin
                o_result.status = mbrd_pkg::ST_IGNORE;
            end else if (bad) begin
                o_result.status = mbrd_pkg::ST_ERROR;
            end else begin
                o_result.status    = mbrd_pkg::ST_ACCEPT;
                o_result.func_code = fc;
                if (fc != mbrd_pkg::FC_SPECIAL) begin
                    o_result.reg_start = h_addr;
                    o_result.count_val = h_cnt;
                end
                if (fc == mbrd_pkg::FC_WRITE_MULTI) o_result.byte_cnt = h_len;
            end
            // back to frame idle
            n_crc   = mbrd_pkg::CRC_INIT;
            n_match = 1'b0;
            n_func  = '0;
            n_addr  = '0;
            n_cnt   = '0;
            n_len   = '0;
            n_hold  = '0;
            n_dly0  = '0;
            n_dly1  = '0;
            n_pos   = '0;
        end else if (r_pos >= POS_W'(7) && r_pos < POS_MAX) begin
            if (!off[0]) begin
                n_hold = i_byte;
            end else if (r_match && r_func == mbrd_pkg::FUNC_WRITE_MULTI &&
                         CW'(off) < CW'(r_len)) begin
                o_result.valid     = 1'b1;
                o_result.kind      = mbrd_pkg::KIND_DATA;
                o_result.status    = mbrd_pkg::ST_ACCEPT;
                o_result.func_code = mbrd_pkg::FC_WRITE_MULTI;
                o_result.reg_start = r_addr;
                o_result.count_val = r_cnt;
                o_result.byte_cnt  = r_len;
                o_result.data_word = {r_hold, i_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mbrd_pkg::CRC_INIT;
            r_dly0  <= '0;
            r_dly1  <= '0;
            r_pos   <= '0;
            r_func  <= '0;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_len   <= '0;
            r_hold  <= '0;
            r_match <= 1'b0;
        end else if (i_step) begin
            r_crc   <= n_crc;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_pos   <= n_pos;
            r_func  <= n_func;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_hold  <= n_hold;
            r_match <= n_match;
        end
    end

endmodule
